### rtl/core/jfps_pkg.sv
// Shared widths, reset values, register indexes and controller types for the
// five-point stencil block. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package jfps_pkg;

    localparam int DATA_W    = 48;
    localparam int FRAC_W    = 24;
    localparam int MAX_COLS  = 1024;
    localparam int COL_W     = $clog2(MAX_COLS);
    localparam int TCOL_W    = 11;
    localparam int ROW_W     = 16;
    localparam int CFG_W     = 47;
    localparam int CFG_IDX_W = 3;
    localparam int SQ_W      = 63;

    // Multiplier operand A splits into two PA_W pieces, operand B into two PB_W pieces.
    localparam int PA_W  = 26;
    localparam int PB_W  = 24;
    localparam int SUM_W = 2 * PA_W;
    localparam int MB_W  = 2 * PB_W;
    localparam int PP_W  = PA_W + PB_W;
    localparam int ACC_W = 2 * PP_W;
    localparam int Q_W   = ACC_W - FRAC_W;
    localparam int WIDE_W = 64;

    localparam int S_TDATA_W = 2 * DATA_W;
    localparam int M_TDATA_W = ((DATA_W + SQ_W + 7) / 8) * 8;

    localparam logic [CFG_IDX_W-1:0] CFG_TILE_COLS = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_TILE_ROWS = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_MODE      = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_H_SQ      = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_INV_H_SQ  = CFG_IDX_W'(4);

    localparam logic [TCOL_W-1:0] RST_TILE_COLS = TCOL_W'(1024);
    localparam logic [ROW_W-1:0]  RST_TILE_ROWS = ROW_W'(1024);
    localparam logic [CFG_W-1:0]  RST_H_SQ      = CFG_W'(16);
    localparam logic [CFG_W-1:0]  RST_INV_H_SQ  = CFG_W'(1) << 44;

    localparam logic [TCOL_W-1:0] MIN_DIM  = TCOL_W'(3);
    localparam logic [TCOL_W-1:0] MAX_DIM  = TCOL_W'(MAX_COLS);

    localparam logic [Q_W-1:0] Q_LIM_PROD = Q_W'(1) << 62;
    localparam logic [Q_W-1:0] Q_LIM_SQ   = Q_W'({SQ_W{1'b1}});
    localparam logic [WIDE_W-1:0] SQ_LIM  = WIDE_W'({SQ_W{1'b1}});

    localparam logic signed [WIDE_W-1:0] V_MAX = (WIDE_W'(1) <<< (DATA_W - 1)) - WIDE_W'(1);
    localparam logic signed [WIDE_W-1:0] V_MIN = -V_MAX - WIDE_W'(1);

    typedef enum logic [3:0] {
        S_IDLE,
        S_RD0,
        S_RD1,
        S_SUM,
        S_OPA,
        S_WAIT1,
        S_FIN,
        S_SQ,
        S_WAIT2,
        S_ACC,
        S_OUT
    } t_state;

    typedef struct packed {
        logic accept;
        logic rd_sel;
        logic cap;
        logic mem_we;
        logic sum_en;
        logic mul_start;
        logic mul_sq;
        logic fin_en;
        logic acc_en;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic interior;
        logic mode;
        logic mul_done;
        logic out_free;
    } t_dp_sts;

endpackage

`default_nettype wire

### rtl/core/jfps_mul.sv
// Iterative unsigned multiplier with Q24.24 rounding and clamping.
// Four partial products, summed in turn into a shifted accumulator; depends on jfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jfps_mul (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [jfps_pkg::SUM_W-1:0]  i_mag_a,
    input  logic [jfps_pkg::MB_W-1:0]   i_mag_b,
    input  logic                        i_neg,
    input  logic                        i_sq,
    output logic                        o_done,
    output logic [jfps_pkg::SQ_W-1:0]   o_mag
);

    localparam logic [2:0] PP_CNT   = 3'd4;
    localparam logic [2:0] CNT_LAST = 3'd5;

    logic [jfps_pkg::SUM_W-1:0] r_a;
    logic [jfps_pkg::MB_W-1:0]  r_b;
    logic                       r_neg;
    logic                       r_sq;
    logic                       r_busy;
    logic [2:0]                 r_cnt;
    logic                       r_done;
    logic [jfps_pkg::PP_W-1:0]  r_pp;
    logic [1:0]                 r_pp_step;
    logic [jfps_pkg::ACC_W-1:0] r_acc;
    logic [jfps_pkg::SQ_W-1:0]  r_res;

    logic [1:0]                 w_step;
    logic [jfps_pkg::PA_W-1:0]  w_a_pc;
    logic [jfps_pkg::PB_W-1:0]  w_b_pc;
    logic [jfps_pkg::PP_W-1:0]  w_pp;
    logic [jfps_pkg::ACC_W-1:0] w_pp_ext;
    logic [jfps_pkg::ACC_W-1:0] w_pp_sh;
    logic [jfps_pkg::ACC_W-1:0] w_k;
    logic [jfps_pkg::ACC_W-1:0] w_rnd;
    logic [jfps_pkg::Q_W-1:0]   w_q;
    logic [jfps_pkg::Q_W-1:0]   w_lim;
    logic [jfps_pkg::SQ_W-1:0]  w_res;

    always_comb begin
        w_step = r_cnt[1:0];
        w_a_pc = w_step[1] ? r_a[jfps_pkg::SUM_W-1:jfps_pkg::PA_W] : r_a[jfps_pkg::PA_W-1:0];
        w_b_pc = w_step[0] ? r_b[jfps_pkg::MB_W-1:jfps_pkg::PB_W] : r_b[jfps_pkg::PB_W-1:0];
        w_pp   = w_a_pc * w_b_pc;
        w_pp_ext = jfps_pkg::ACC_W'(r_pp);
        unique case (r_pp_step)
            2'd0: w_pp_sh = w_pp_ext;
            2'd1: w_pp_sh = w_pp_ext << jfps_pkg::PB_W;
            2'd2: w_pp_sh = w_pp_ext << jfps_pkg::PA_W;
            2'd3: w_pp_sh = w_pp_ext << jfps_pkg::PP_W;
            default: w_pp_sh = w_pp_ext;
        endcase
        // Half-LSB bias, one less for negative products so ties go toward +infinity.
        w_k   = (jfps_pkg::ACC_W'(1) << (jfps_pkg::FRAC_W - 1)) - jfps_pkg::ACC_W'(r_neg);
        w_rnd = r_acc + w_k;
        w_q   = w_rnd[jfps_pkg::ACC_W-1:jfps_pkg::FRAC_W];
        w_lim = r_sq ? jfps_pkg::Q_LIM_SQ : jfps_pkg::Q_LIM_PROD;
        w_res = (w_q > w_lim) ? w_lim[jfps_pkg::SQ_W-1:0] : w_q[jfps_pkg::SQ_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= 3'd0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= 3'd0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == CNT_LAST) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_a   <= i_mag_a;
            r_b   <= i_mag_b;
            r_neg <= i_neg;
            r_sq  <= i_sq;
            r_acc <= '0;
        end else if (r_busy) begin
            if (r_cnt < PP_CNT) begin
                r_pp      <= w_pp;
                r_pp_step <= w_step;
            end
            if (r_cnt != 3'd0 && r_cnt <= PP_CNT) begin
                r_acc <= r_acc + w_pp_sh;
            end
            if (r_cnt == CNT_LAST) begin
                r_res <= w_res;
            end
        end
    end

    assign o_done = r_done;
    assign o_mag  = r_res;

endmodule

`default_nettype wire

### rtl/core/jfps_dp.sv
// Stencil datapath: configuration registers, tile counters, line stores,
// window sums, output register and the shared multiplier. Uses jfps_pkg, jfps_mul.
`timescale 1ns / 1ps
`default_nettype none

module jfps_dp (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jfps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jfps_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic [jfps_pkg::S_TDATA_W-1:0]    i_s_tdata,  // u_in, f_in
    input  jfps_pkg::t_dp_cmd                 i_cmd,
    output jfps_pkg::t_dp_sts                 o_sts,
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [jfps_pkg::M_TDATA_W-1:0]    o_m_tdata,  // value_out, sum_squares
    output logic                              o_m_tlast
);

    localparam int DW = jfps_pkg::DATA_W;
    localparam int SW = jfps_pkg::SUM_W;
    localparam int WW = jfps_pkg::WIDE_W;

    // Configuration
    logic [jfps_pkg::TCOL_W-1:0] r_tile_cols;
    logic [jfps_pkg::ROW_W-1:0]  r_tile_rows;
    logic                        r_mode;
    logic [jfps_pkg::CFG_W-1:0]  r_h_sq;
    logic [jfps_pkg::CFG_W-1:0]  r_inv_h_sq;

    // Tile position
    logic [jfps_pkg::COL_W-1:0]  r_col_count;
    logic [jfps_pkg::ROW_W-1:0]  r_row_count;
    logic [jfps_pkg::COL_W-1:0]  r_col;
    logic                        r_interior;
    logic                        r_last;

    // Line stores
    logic [DW-1:0] mem_above  [jfps_pkg::MAX_COLS];
    logic [DW-1:0] mem_centre [jfps_pkg::MAX_COLS];
    logic [DW-1:0] mem_f      [jfps_pkg::MAX_COLS];
    logic [DW-1:0] r_above_q;
    logic [DW-1:0] r_centre_q;
    logic [DW-1:0] r_f_q;

    // Window and arithmetic
    logic [DW-1:0]               r_u;
    logic [DW-1:0]               r_f;
    logic [DW-1:0]               r_north;
    logic [DW-1:0]               r_cent;
    logic [DW-1:0]               r_fc;
    logic signed [SW-1:0]        r_sum4;
    logic                        r_op_neg;
    logic signed [DW-1:0]        r_v;
    logic [jfps_pkg::SQ_W-1:0]   r_accum;

    // Output register
    logic                        r_out_valid;
    logic [DW-1:0]               r_out_value;
    logic                        r_out_last;
    logic [jfps_pkg::SQ_W-1:0]   r_out_sum;

    logic [jfps_pkg::TCOL_W-1:0] w_cols;
    logic [jfps_pkg::ROW_W-1:0]  w_rows;
    logic [jfps_pkg::TCOL_W-1:0] w_cnt_ext;
    logic [jfps_pkg::TCOL_W-1:0] w_c11;
    logic [jfps_pkg::COL_W-1:0]  w_c;
    logic                        w_interior;
    logic                        w_last;
    logic                        w_row_end;
    logic                        w_tile_end;
    logic [jfps_pkg::COL_W-1:0]  w_rd_a;
    logic [jfps_pkg::COL_W-1:0]  w_rd_c;

    logic signed [SW-1:0]        w_sum4;
    logic signed [SW-1:0]        w_opnd;
    logic [SW-1:0]               w_op_mag;
    logic [DW-1:0]               w_v_mag;
    logic [SW-1:0]               w_mag_a;
    logic [jfps_pkg::MB_W-1:0]   w_mag_b;
    logic                        w_neg;
    logic                        w_mul_done;
    logic [jfps_pkg::SQ_W-1:0]   w_mul_mag;
    logic signed [WW-1:0]        w_mag64;
    logic signed [WW-1:0]        w_prod;
    logic signed [WW-1:0]        w_jac;
    logic signed [WW-1:0]        w_res;
    logic signed [WW-1:0]        w_pre;
    logic signed [DW-1:0]        w_v;
    logic [WW-1:0]               w_acc_sum;

    // Geometry, clamped; a column counter past the row end wraps to the last column.
    always_comb begin
        w_cols = (r_tile_cols < jfps_pkg::MIN_DIM) ? jfps_pkg::MIN_DIM
               : ((r_tile_cols > jfps_pkg::MAX_DIM) ? jfps_pkg::MAX_DIM : r_tile_cols);
        w_rows = (r_tile_rows < jfps_pkg::ROW_W'(jfps_pkg::MIN_DIM))
               ? jfps_pkg::ROW_W'(jfps_pkg::MIN_DIM) : r_tile_rows;
        w_cnt_ext  = jfps_pkg::TCOL_W'(r_col_count);
        w_c11      = (w_cnt_ext >= w_cols) ? w_cols - jfps_pkg::TCOL_W'(1) : w_cnt_ext;
        w_c        = w_c11[jfps_pkg::COL_W-1:0];
        w_interior = (r_row_count >= jfps_pkg::ROW_W'(2)) && (w_c11 >= jfps_pkg::TCOL_W'(1))
                     && (w_c11 <= w_cols - jfps_pkg::TCOL_W'(2));
        w_tile_end = r_row_count >= w_rows - jfps_pkg::ROW_W'(1);
        w_last     = w_tile_end && (w_c11 == w_cols - jfps_pkg::TCOL_W'(2));
        w_row_end  = w_c11 >= w_cols - jfps_pkg::TCOL_W'(1);
        w_rd_a     = i_cmd.rd_sel ? r_col - jfps_pkg::COL_W'(1) : r_col;
        w_rd_c     = i_cmd.rd_sel ? r_col + jfps_pkg::COL_W'(1) : r_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tile_cols <= jfps_pkg::RST_TILE_COLS;
            r_tile_rows <= jfps_pkg::RST_TILE_ROWS;
            r_mode      <= 1'b0;
            r_h_sq      <= jfps_pkg::RST_H_SQ;
            r_inv_h_sq  <= jfps_pkg::RST_INV_H_SQ;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                jfps_pkg::CFG_TILE_COLS: r_tile_cols <= i_cfg_wdata[jfps_pkg::TCOL_W-1:0];
                jfps_pkg::CFG_TILE_ROWS: r_tile_rows <= i_cfg_wdata[jfps_pkg::ROW_W-1:0];
                jfps_pkg::CFG_MODE:      r_mode      <= i_cfg_wdata[0];
                jfps_pkg::CFG_H_SQ:      r_h_sq      <= i_cfg_wdata;
                jfps_pkg::CFG_INV_H_SQ:  r_inv_h_sq  <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Counters advance as the item is taken.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col_count <= '0;
            r_row_count <= '0;
        end else if (i_cmd.accept) begin
            if (w_row_end) begin
                r_col_count <= '0;
                r_row_count <= w_tile_end ? '0 : r_row_count + jfps_pkg::ROW_W'(1);
            end else begin
                r_col_count <= w_c + jfps_pkg::COL_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_col      <= w_c;
            r_interior <= w_interior;
            r_last     <= w_last;
            r_u        <= i_s_tdata[DW-1:0];
            r_f        <= i_s_tdata[2*DW-1:DW];
        end
    end

    // Line stores: read north/centre/f at the column, then west/east while the column shifts down.
    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem_above[r_col] <= r_centre_q;
        end
        r_above_q <= mem_above[w_rd_a];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem_centre[r_col] <= r_u;
        end
        r_centre_q <= mem_centre[w_rd_c];
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_we) begin
            mem_f[r_col] <= r_f;
        end
        r_f_q <= mem_f[r_col];
    end

    always_comb begin
        w_sum4 = $signed({{(SW-DW){r_north[DW-1]}}, r_north})
               + $signed({{(SW-DW){r_u[DW-1]}}, r_u})
               + $signed({{(SW-DW){r_above_q[DW-1]}}, r_above_q})
               + $signed({{(SW-DW){r_centre_q[DW-1]}}, r_centre_q});
        w_opnd = r_mode ? r_sum4 - ($signed({{(SW-DW){r_cent[DW-1]}}, r_cent}) <<< 2)
                        : $signed({{(SW-DW){r_fc[DW-1]}}, r_fc});
        w_op_mag = w_opnd[SW-1] ? SW'(-w_opnd) : SW'(w_opnd);
        w_v_mag  = r_v[DW-1] ? DW'(~r_v + DW'(1)) : DW'(r_v);
        w_mag_a  = i_cmd.mul_sq ? SW'(w_v_mag) : w_op_mag;
        w_mag_b  = i_cmd.mul_sq ? w_v_mag
                 : jfps_pkg::MB_W'(r_mode ? r_inv_h_sq : r_h_sq);
        w_neg    = i_cmd.mul_sq ? 1'b0 : w_opnd[SW-1];

        w_mag64 = $signed(WW'(w_mul_mag));
        w_prod  = r_op_neg ? -w_mag64 : w_mag64;
        // Divide by four rounding ties up: floor((x + 2) / 4).
        w_jac   = ($signed({{(WW-SW){r_sum4[SW-1]}}, r_sum4}) + w_prod + WW'(2)) >>> 2;
        w_res   = $signed({{(WW-DW){r_fc[DW-1]}}, r_fc}) + w_prod;
        w_pre   = r_mode ? w_res : w_jac;
        w_v     = (w_pre > jfps_pkg::V_MAX) ? jfps_pkg::V_MAX[DW-1:0]
                : ((w_pre < jfps_pkg::V_MIN) ? jfps_pkg::V_MIN[DW-1:0] : w_pre[DW-1:0]);
        w_acc_sum = WW'(r_accum) + WW'(w_mul_mag);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.cap) begin
            r_north <= r_above_q;
            r_cent  <= r_centre_q;
            r_fc    <= r_f_q;
        end
        if (i_cmd.sum_en) begin
            r_sum4 <= w_sum4;
        end
        if (i_cmd.mul_start && !i_cmd.mul_sq) begin
            r_op_neg <= w_neg;
        end
        if (i_cmd.fin_en) begin
            r_v <= w_v;
        end
    end

    jfps_mul u_mul (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (i_cmd.mul_start),
        .i_mag_a (w_mag_a),
        .i_mag_b (w_mag_b),
        .i_neg   (w_neg),
        .i_sq    (i_cmd.mul_sq),
        .o_done  (w_mul_done),
        .o_mag   (w_mul_mag)
    );

    // Square accumulator: saturate, drop to zero after each last interior point.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_accum <= '0;
        end else if (i_cmd.acc_en) begin
            r_accum <= (w_acc_sum > jfps_pkg::SQ_LIM) ? jfps_pkg::SQ_LIM[jfps_pkg::SQ_W-1:0]
                                                      : w_acc_sum[jfps_pkg::SQ_W-1:0];
        end else if (i_cmd.out_load && r_last) begin
            r_accum <= '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.out_load) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.out_load) begin
            r_out_value <= r_v;
            r_out_last  <= r_last;
            r_out_sum   <= (r_last && r_mode) ? r_accum : '0;
        end
    end

    always_comb begin
        o_sts.interior = r_interior;
        o_sts.mode     = r_mode;
        o_sts.mul_done = w_mul_done;
        o_sts.out_free = !r_out_valid;
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = {{(jfps_pkg::M_TDATA_W - DW - jfps_pkg::SQ_W){1'b0}},
                         r_out_sum, r_out_value};
    assign o_m_tlast  = r_out_last;

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.out_load |-> !r_out_valid)
        else $error("output register loaded while still full");

    a_sum_only_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !r_out_last) |-> (r_out_sum == '0))
        else $error("sum of squares shown outside the last point");

    a_fin_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fin_en |-> $past(w_mul_done))
        else $error("result formed before the product was ready");

    a_acc_after_mul: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.acc_en |-> $past(w_mul_done))
        else $error("square accumulated before the product was ready");

endmodule

`default_nettype wire

### rtl/core/jfps_ctrl.sv
// Stencil controller: sequences line store reads, multiplier passes and
// output loading for one item at a time. Uses jfps_pkg.
`timescale 1ns / 1ps
`default_nettype none

module jfps_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    output logic              o_s_tready,
    input  jfps_pkg::t_dp_sts i_sts,
    output jfps_pkg::t_dp_cmd o_cmd
);

    jfps_pkg::t_state r_state;
    jfps_pkg::t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= jfps_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_s_tready = 1'b0;
        unique case (r_state)
            jfps_pkg::S_IDLE: begin
                o_s_tready   = 1'b1;
                o_cmd.accept = i_s_tvalid;
                if (i_s_tvalid) begin
                    n_state = jfps_pkg::S_RD0;
                end
            end
            jfps_pkg::S_RD0: begin
                n_state = jfps_pkg::S_RD1;
            end
            jfps_pkg::S_RD1: begin
                // Shift the column down the stores; halo points end here.
                o_cmd.rd_sel = 1'b1;
                o_cmd.cap    = 1'b1;
                o_cmd.mem_we = 1'b1;
                n_state = i_sts.interior ? jfps_pkg::S_SUM : jfps_pkg::S_IDLE;
            end
            jfps_pkg::S_SUM: begin
                o_cmd.sum_en = 1'b1;
                n_state = jfps_pkg::S_OPA;
            end
            jfps_pkg::S_OPA: begin
                o_cmd.mul_start = 1'b1;
                n_state = jfps_pkg::S_WAIT1;
            end
            jfps_pkg::S_WAIT1: begin
                if (i_sts.mul_done) begin
                    n_state = jfps_pkg::S_FIN;
                end
            end
            jfps_pkg::S_FIN: begin
                o_cmd.fin_en = 1'b1;
                n_state = i_sts.mode ? jfps_pkg::S_SQ : jfps_pkg::S_OUT;
            end
            jfps_pkg::S_SQ: begin
                o_cmd.mul_start = 1'b1;
                o_cmd.mul_sq    = 1'b1;
                n_state = jfps_pkg::S_WAIT2;
            end
            jfps_pkg::S_WAIT2: begin
                if (i_sts.mul_done) begin
                    n_state = jfps_pkg::S_ACC;
                end
            end
            jfps_pkg::S_ACC: begin
                o_cmd.acc_en = 1'b1;
                n_state = jfps_pkg::S_OUT;
            end
            jfps_pkg::S_OUT: begin
                // Hold until the previous result has been taken.
                if (i_sts.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = jfps_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = jfps_pkg::S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

### rtl/core/jacobi_five_point_stencil.sv
// Five-point Jacobi / residual stencil over a raster-streamed tile, halo included.
// Top level: controller and datapath. Uses jfps_pkg, jfps_ctrl, jfps_dp.
//
// Points enter one at a time on the s-side stream (u in tdata[47:0], f in tdata[95:48]),
// and each interior point, found when the point below it arrives, gives one item on the
// m-side stream: new u (mode 0) or residual (mode 1) in tdata[47:0], the tile's saturated
// sum of squared residuals in tdata[110:48] with tlast on the last interior point. One item
// is in work at a time: a halo point goes through the line store reads only; an interior
// point then also uses the 26x24 multiplier, which builds each Q24.24 product from four
// partial products, once per point in mode 0 and twice in mode 1. A finished result waits
// in the output register while the next point is taken. Line stores are not cleared after
// reset; the first two rows of a tile fill them.
// Write configuration only while the block is idle.
`timescale 1ns / 1ps
`default_nettype none

module jacobi_five_point_stencil (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_we,
    input  logic [jfps_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [jfps_pkg::CFG_W-1:0]        i_cfg_wdata,
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    input  logic [jfps_pkg::S_TDATA_W-1:0]    i_s_tdata,   // u_in, f_in
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    output logic [jfps_pkg::M_TDATA_W-1:0]    o_m_tdata,   // value_out, sum_squares
    output logic                              o_m_tlast    // is_last
);

    jfps_pkg::t_dp_cmd w_cmd;
    jfps_pkg::t_dp_sts w_sts;

    jfps_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (w_sts),
        .o_cmd      (w_cmd)
    );

    jfps_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tdata   (i_s_tdata),
        .i_cmd       (w_cmd),
        .o_sts       (w_sts),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

endmodule

`default_nettype wire

### verif/testbench.sv
// Self-checking testbench for jacobi_five_point_stencil: streams tiles of grid points,
// predicts each interior result in Q24.24 and checks every m-side item against it.
// Depends on jfps_pkg and the RTL under rtl/core.
`timescale 1ns / 1ps

module testbench;

    localparam int DATA_W    = jfps_pkg::DATA_W;
    localparam int FRAC_W    = jfps_pkg::FRAC_W;
    localparam int CFG_W     = jfps_pkg::CFG_W;
    localparam int CFG_IDX_W = jfps_pkg::CFG_IDX_W;
    localparam int TCOL_W    = jfps_pkg::TCOL_W;
    localparam int ROW_W     = jfps_pkg::ROW_W;
    localparam int SQ_W      = jfps_pkg::SQ_W;
    localparam int MAX_COLS  = jfps_pkg::MAX_COLS;
    localparam int S_TDATA_W = jfps_pkg::S_TDATA_W;
    localparam int M_TDATA_W = jfps_pkg::M_TDATA_W;
    localparam int MIN_SIDE  = 32'(jfps_pkg::MIN_DIM);

    localparam int RESET_CYCLES    = 6;
    localparam int STALL_LIMIT     = 2000;
    localparam int SETTLE_CYCLES   = 40;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int MAX_GAP         = 20;

    localparam logic [DATA_W-1:0] U_MAX   = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] U_MIN   = {1'b1, {(DATA_W-1){1'b0}}};
    localparam logic [CFG_W-1:0]  Q_ONE   = CFG_W'(1) << FRAC_W;
    localparam logic [CFG_W-1:0]  CFG_MAX = {CFG_W{1'b1}};
    localparam int                ROW_MAX = (1 << ROW_W) - 1;
    localparam logic MODE_JACOBI   = 1'b0;
    localparam logic MODE_RESIDUAL = 1'b1;

    typedef logic signed [127:0] t_wide;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              last;
        logic [SQ_W-1:0]   squares;
    } t_stencil_result;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n;
    logic                 i_cfg_we;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [CFG_W-1:0]     i_cfg_wdata;
    logic                 i_s_tvalid;
    logic                 o_s_tready;
    logic [S_TDATA_W-1:0] i_s_tdata;    // u_in, f_in
    logic                 o_m_tvalid;
    logic                 i_m_tready;
    logic [M_TDATA_W-1:0] o_m_tdata;    // value_out, sum_squares
    logic                 o_m_tlast;    // is_last

    // Predictor copy of the registers and the line stores
    logic [TCOL_W-1:0] tile_cols_reg;
    logic [ROW_W-1:0]  tile_rows_reg;
    logic              mode_reg;
    logic [CFG_W-1:0]  h_sq_reg;
    logic [CFG_W-1:0]  inv_h_sq_reg;
    logic [DATA_W-1:0] u_above [MAX_COLS];
    logic [DATA_W-1:0] u_centre [MAX_COLS];
    logic [DATA_W-1:0] f_centre [MAX_COLS];
    int unsigned       col_pos;
    int unsigned       row_pos;
    logic [SQ_W-1:0]   square_sum;
    t_stencil_result   expected_results [$];

    int send_idle_pct;
    int recv_idle_pct;
    int hold_left;
    int idle_cycles;
    int mismatches;
    int points_sent;
    int results_checked;
    int tile_ends;

    jacobi_five_point_stencil dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata),
        .i_s_tvalid  (i_s_tvalid),
        .o_s_tready  (o_s_tready),
        .i_s_tdata   (i_s_tdata),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata),
        .o_m_tlast   (o_m_tlast)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // Q24.24 product rounded to nearest, ties toward +inf, clamped to +-lim
    function automatic t_wide fixed_mul(t_wide a, t_wide b, t_wide lim);
        t_wide p;
        p = (a * b + (t_wide'(1) <<< (FRAC_W - 1))) >>> FRAC_W;
        if (p > lim) return lim;
        if (p < -lim) return -lim;
        return p;
    endfunction

    function automatic logic [DATA_W-1:0] saturate(t_wide x);
        t_wide hi;
        t_wide lo;
        hi = (t_wide'(1) <<< (DATA_W - 1)) - t_wide'(1);
        lo = -hi - t_wide'(1);
        if (x > hi) return U_MAX;
        if (x < lo) return U_MIN;
        return x[DATA_W-1:0];
    endfunction

    // Take one grid point; queue the result of the interior point above it, if any.
    function automatic void advance_stencil(logic [DATA_W-1:0] u, logic [DATA_W-1:0] f);
        int unsigned     cols;
        int unsigned     rows;
        int unsigned     c;
        t_wide           north, south, west, east, centre, fv, sum4, mag, sq, total;
        t_wide           prod_lim, sq_lim, h, inv;
        t_stencil_result r;
        cols = 32'(tile_cols_reg);
        if (cols < MIN_SIDE) cols = MIN_SIDE;
        if (cols > MAX_COLS) cols = MAX_COLS;
        rows = 32'(tile_rows_reg);
        if (rows < MIN_SIDE) rows = MIN_SIDE;
        c = col_pos;
        if (c >= cols) c = cols - 1;
        if (row_pos >= 2 && c >= 1 && c <= cols - 2) begin
            north    = t_wide'($signed(u_above[c]));
            west     = t_wide'($signed(u_above[c-1]));
            centre   = t_wide'($signed(u_centre[c]));
            east     = t_wide'($signed(u_centre[c+1]));
            south    = t_wide'($signed(u));
            fv       = t_wide'($signed(f_centre[c]));
            sum4     = north + south + west + east;
            prod_lim = t_wide'(1) <<< 62;
            sq_lim   = (t_wide'(1) <<< SQ_W) - t_wide'(1);
            h        = {81'd0, h_sq_reg};
            inv      = {81'd0, inv_h_sq_reg};
            r.last   = (row_pos >= rows - 1) && (c == cols - 2);
            if (mode_reg == MODE_JACOBI) begin
                r.value = saturate((sum4 + fixed_mul(fv, h, prod_lim) + t_wide'(2)) >>> 2);
            end else begin
                r.value = saturate(fv + fixed_mul(sum4 - centre * t_wide'(4), inv, prod_lim));
                mag = t_wide'($signed(r.value));
                if (mag < 0) mag = -mag;
                sq = fixed_mul(mag, mag, sq_lim);
                total = {65'd0, square_sum};
                total = total + sq;
                square_sum = (total > sq_lim) ? {SQ_W{1'b1}} : total[SQ_W-1:0];
            end
            r.squares = (r.last && mode_reg == MODE_RESIDUAL) ? square_sum : '0;
            expected_results.insert(expected_results.size(), r);
            if (r.last) square_sum = '0;
        end
        u_above[c]  = u_centre[c];
        u_centre[c] = u;
        f_centre[c] = f;
        if (c >= cols - 1) begin
            col_pos = 0;
            if (row_pos >= rows - 1) row_pos = 0;
            else row_pos++;
        end else begin
            col_pos = c + 1;
        end
    endfunction

    function automatic logic [DATA_W-1:0] pick_sample();
        int unsigned sel;
        logic [63:0] r;
        sel = $urandom_range(19);
        r   = {$urandom, $urandom};
        case (sel)
            0: return U_MAX;
            1: return U_MIN;
            2: return '0;
            3, 4, 5, 6, 7, 8, 9, 10, 11: return {{(DATA_W-28){r[27]}}, r[27:0]};
            default: return r[DATA_W-1:0];
        endcase
    endfunction

    function automatic logic [CFG_W-1:0] pick_coef();
        int unsigned sel;
        logic [63:0] r;
        sel = $urandom_range(9);
        r   = {$urandom, $urandom};
        case (sel)
            0: return '0;
            1: return CFG_MAX;
            2: return Q_ONE;
            3, 4: return CFG_W'($urandom_range(32'h0400_0000));
            default: return r[CFG_W-1:0];
        endcase
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
        @(negedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= value;
        @(negedge i_clk);
        i_cfg_we    <= 1'b0;
        case (idx)
            jfps_pkg::CFG_TILE_COLS: tile_cols_reg = value[TCOL_W-1:0];
            jfps_pkg::CFG_TILE_ROWS: tile_rows_reg = value[ROW_W-1:0];
            jfps_pkg::CFG_MODE:      mode_reg      = value[0];
            jfps_pkg::CFG_H_SQ:      h_sq_reg      = value;
            jfps_pkg::CFG_INV_H_SQ:  inv_h_sq_reg  = value;
            default: ;
        endcase
    endtask

    task automatic configure_tile(input int cols, input int rows, input logic mode,
                                  input logic [CFG_W-1:0] h, input logic [CFG_W-1:0] inv);
        write_reg(jfps_pkg::CFG_TILE_COLS, CFG_W'(cols));
        write_reg(jfps_pkg::CFG_TILE_ROWS, CFG_W'(rows));
        write_reg(jfps_pkg::CFG_MODE, CFG_W'(mode));
        write_reg(jfps_pkg::CFG_H_SQ, h);
        write_reg(jfps_pkg::CFG_INV_H_SQ, inv);
    endtask

    task automatic send_point(input logic [DATA_W-1:0] u, input logic [DATA_W-1:0] f);
        int gap;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < send_idle_pct) gap++;
        @(negedge i_clk);
        if (gap > 0) begin
            i_s_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_s_tvalid <= 1'b1;
        i_s_tdata  <= {f, u};
        @(posedge i_clk);
        while (!o_s_tready) @(posedge i_clk);
        advance_stencil(u, f);
        points_sent++;
    endtask

    task automatic send_points(input int count);
        repeat (count) send_point(pick_sample(), pick_sample());
    endtask

    // Drop valid, wait for every queued result, then let any halo point finish.
    task automatic wait_idle();
        @(negedge i_clk);
        i_s_tvalid <= 1'b0;
        while (expected_results.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    // Every extreme is positive: the product clamps and the Jacobi update saturates high.
    // Column and row counts below the minimum are clamped to three.
    task automatic test_saturating_jacobi();
        write_reg(jfps_pkg::CFG_TILE_COLS, CFG_W'(2));
        write_reg(jfps_pkg::CFG_TILE_ROWS, CFG_W'(0));
        write_reg(jfps_pkg::CFG_H_SQ, CFG_MAX);
        repeat (9) send_point(U_MAX, U_MAX);
        wait_idle();
    endtask

    // Residual with the reset inv_h_sq: large negative residuals saturate low, and their
    // squares and the sum saturate at the top of the accumulator.
    task automatic test_saturating_residual();
        write_reg(jfps_pkg::CFG_TILE_COLS, CFG_W'(4));
        write_reg(jfps_pkg::CFG_TILE_ROWS, CFG_W'(3));
        write_reg(jfps_pkg::CFG_MODE, CFG_W'(MODE_RESIDUAL));
        repeat (4) send_point(U_MIN, U_MAX);
        send_point(U_MIN, U_MIN);
        send_point(U_MAX, U_MAX);
        send_point(U_MAX, U_MIN);
        send_point(U_MIN, U_MAX);
        repeat (4) send_point(U_MIN, '0);
        wait_idle();
    endtask

    task automatic test_output_backpressure();
        send_idle_pct = 0;
        recv_idle_pct = 0;
        configure_tile(5, 5, 1'($urandom_range(1)), pick_coef(), pick_coef());
        @(posedge i_clk);
        hold_left = HOLD_OFF_CYCLES;
        send_points(25);
        wait_idle();
    endtask

    task automatic test_geometry_change_midtile();
        configure_tile(6, ROW_MAX, MODE_RESIDUAL, pick_coef(), pick_coef());
        send_points(4 * 6 + 3);
        wait_idle();
        // row counter is past the new last row: the rest of this row closes the tile
        write_reg(jfps_pkg::CFG_TILE_ROWS, CFG_W'(4));
        send_points(3);
        wait_idle();
        write_reg(jfps_pkg::CFG_TILE_ROWS, CFG_W'(ROW_MAX));
        send_points(2 * 6 + 4);
        wait_idle();
        // column counter now sits beyond the new row end and wraps at once
        write_reg(jfps_pkg::CFG_TILE_COLS, CFG_W'(3));
        write_reg(jfps_pkg::CFG_TILE_ROWS, CFG_W'(4));
        send_points(1 + 3);
        wait_idle();
    endtask

    task automatic test_random_tiles(input int budget);
        int start;
        int cols;
        int rows;
        int eff_cols;
        int eff_rows;
        start = points_sent;
        while (points_sent - start < budget) begin
            case ($urandom_range(9))
                0: cols = $urandom_range(2);
                1, 2, 3, 4, 5, 6: cols = $urandom_range(8, 3);
                default: cols = $urandom_range(32, 9);
            endcase
            rows = ($urandom_range(9) == 0) ? $urandom_range(2) : $urandom_range(6, 3);
            configure_tile(cols, rows, 1'($urandom_range(1)), pick_coef(), pick_coef());
            eff_cols = (cols < MIN_SIDE) ? MIN_SIDE : cols;
            eff_rows = (rows < MIN_SIDE) ? MIN_SIDE : rows;
            send_points(eff_cols * eff_rows);
            wait_idle();
        end
    endtask

    always @(negedge i_clk) begin
        if (hold_left > 0) begin
            i_m_tready <= 1'b0;
            hold_left = hold_left - 1;
        end else begin
            i_m_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    always @(posedge i_clk) begin : check_results
        t_stencil_result want;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (expected_results.size() == 0) begin
                $display("%0t: unexpected item value %h last %b squares %h", $time,
                         o_m_tdata[DATA_W-1:0], o_m_tlast, o_m_tdata[DATA_W +: SQ_W]);
                mismatches++;
            end else begin
                want = expected_results.pop_front();
                results_checked++;
                if (want.last) tile_ends++;
                if (o_m_tdata[DATA_W-1:0] !== want.value) begin
                    $display("%0t: value_out expected %h got %h", $time, want.value,
                             o_m_tdata[DATA_W-1:0]);
                    mismatches++;
                end
                if (o_m_tlast !== want.last) begin
                    $display("%0t: is_last expected %b got %b", $time, want.last, o_m_tlast);
                    mismatches++;
                end
                if (o_m_tdata[DATA_W +: SQ_W] !== want.squares) begin
                    $display("%0t: sum_squares expected %h got %h", $time, want.squares,
                             o_m_tdata[DATA_W +: SQ_W]);
                    mismatches++;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_tvalid && o_s_tready) || (o_m_tvalid && i_m_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("%0t: no item moved for %0d cycles", $time, STALL_LIMIT);
            $display("*** FAILED ***");
            $finish;
        end
    end

    initial begin
        i_rst_n       = 1'b0;
        i_cfg_we      = 1'b0;
        i_cfg_index   = '0;
        i_cfg_wdata   = '0;
        i_s_tvalid    = 1'b0;
        i_s_tdata     = '0;
        i_m_tready    = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_left     = 0;
        idle_cycles   = 0;
        mismatches    = 0;
        points_sent   = 0;
        results_checked = 0;
        tile_ends     = 0;
        tile_cols_reg = jfps_pkg::RST_TILE_COLS;
        tile_rows_reg = jfps_pkg::RST_TILE_ROWS;
        mode_reg      = MODE_JACOBI;
        h_sq_reg      = jfps_pkg::RST_H_SQ;
        inv_h_sq_reg  = jfps_pkg::RST_INV_H_SQ;
        col_pos       = 0;
        row_pos       = 0;
        square_sum    = '0;
        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_saturating_jacobi();
        test_saturating_residual();
        test_output_backpressure();
        test_geometry_change_midtile();

        send_idle_pct = 38;
        recv_idle_pct = 61;
        test_random_tiles(170);
        send_idle_pct = 61;
        recv_idle_pct = 38;
        test_random_tiles(170);
        send_idle_pct = 0;
        recv_idle_pct = 0;
        test_random_tiles(160);

        wait_idle();
        $display("Run: %0d grid points streamed, %0d results checked, %0d tile ends.",
                 points_sent, results_checked, tile_ends);
        $display("Both modes, saturation, clamped and changed geometry, output stalls.");
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
